// ===== design/lbbc_pkg.sv =====
// ----------------------------------------------------------------------------
// lbbc_pkg
// Shared constants and types for the byte-budget LRU cache.
// ----------------------------------------------------------------------------
package lbbc_pkg;

  localparam int ENTRIES = 32;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int FID_W   = 32;
  localparam int MIP_W   = 4;
  localparam int KEY_W   = FID_W + MIP_W;
  localparam int COST_W  = 31;
  localparam int TOT_W   = 40;
  localparam int DIM_W   = 15;
  localparam int N_W     = 2 * DIM_W;

  // cost = ((n * 0x55555555) >> 30) * 4 + 1024, split in two partial products
  localparam logic [15:0] COST_MUL_LO = 16'h5555;
  localparam logic [14:0] COST_MUL_HI = 15'h5555;
  localparam logic [32:0] COST_BASE   = 33'd1024;
  localparam logic [COST_W-1:0] COST_MAX = '1;
  localparam logic [TOT_W-1:0]  TOT_MAX  = '1;

  localparam logic [1:0] REQ_ACCESS = 2'd0;
  localparam logic [1:0] REQ_SHRINK = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  localparam logic [2:0] KIND_HIT     = 3'd0;
  localparam logic [2:0] KIND_INSERT  = 3'd1;
  localparam logic [2:0] KIND_FULL    = 3'd2;
  localparam logic [2:0] KIND_EVICT   = 3'd3;
  localparam logic [2:0] KIND_SHRUNK  = 3'd4;
  localparam logic [2:0] KIND_CLEARED = 3'd5;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [COST_W-1:0] cost;
    logic [IDX_W-1:0]  rank;
  } entry_t;

endpackage

// ===== design/lru_byte_budget_cache_top.sv =====
// ----------------------------------------------------------------------------
// lru_byte_budget_cache_top
// LRU table of cached entries with byte-budget eviction.
// ----------------------------------------------------------------------------
// Access: one table sweep, then a second rank sweep on a hit, or on a miss the
//   cost multiply and write states; a full table gives a KIND_FULL result.
// Shrink: each eviction is a budget check, a memory sweep and a commit; a final
//   check ends it with the closing result. Unused request codes are ignored.
// One transaction at a time. Results are single-cycle strobes; no stall.
// Reset empties the table and loads the default budget; no clearing pass.
module lru_byte_budget_cache_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    req_type_i,
  input  logic [lbbc_pkg::FID_W-1:0]    file_id_i,
  input  logic [lbbc_pkg::MIP_W-1:0]    mip_level_i,
  input  logic                          load_ok_i,
  input  logic [lbbc_pkg::DIM_W-1:0]    tex_width_i,
  input  logic [lbbc_pkg::DIM_W-1:0]    tex_height_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lbbc_pkg::TOT_W-1:0]    cfg_data_i,
  output logic                          res_valid_o,
  output logic [2:0]                    result_kind_o,
  output logic [lbbc_pkg::IDX_W-1:0]    slot_o,
  output logic [lbbc_pkg::FID_W-1:0]    out_file_id_o,
  output logic [lbbc_pkg::MIP_W-1:0]    out_mip_level_o,
  output logic [lbbc_pkg::TOT_W-1:0]    total_bytes_o,
  output logic                          last_o
);

  localparam logic [lbbc_pkg::IDX_W-1:0] LAST_IDX = lbbc_pkg::IDX_W'(lbbc_pkg::ENTRIES - 1);
  localparam logic [lbbc_pkg::CNT_W-1:0] FULL_CNT = lbbc_pkg::CNT_W'(lbbc_pkg::ENTRIES);

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOOK, ST_TOUCH, ST_INS_N, ST_INS_LO, ST_INS_HI, ST_INS_COST,
    ST_INS_WR, ST_SHR_CHK, ST_EVICT
  } state_e;

  state_e                          state_q;
  logic [lbbc_pkg::ENTRIES-1:0]    valid_q;
  logic [lbbc_pkg::CNT_W-1:0]      count_q;
  logic [lbbc_pkg::TOT_W-1:0]      total_q;
  logic [lbbc_pkg::TOT_W-1:0]      budget_q;

  logic [lbbc_pkg::KEY_W-1:0]      key_q;
  logic                            load_ok_q;
  logic [lbbc_pkg::DIM_W-1:0]      w_q, h_q;
  logic [lbbc_pkg::N_W-1:0]        n_q;
  logic [45:0]                     plo_q;
  logic [44:0]                     phi_q;
  logic [lbbc_pkg::COST_W-1:0]     cost_q;

  logic                            sweep_on_q, chk_v_q;
  logic [lbbc_pkg::IDX_W-1:0]      ctr_q, chk_idx_q;
  logic                            hit_q;
  logic [lbbc_pkg::IDX_W-1:0]      hit_slot_q, hit_rank_q;
  logic [lbbc_pkg::IDX_W-1:0]      vic_slot_q;
  logic [lbbc_pkg::KEY_W-1:0]      vic_key_q;
  logic [lbbc_pkg::COST_W-1:0]     vic_cost_q;
  logic                            evict_pend_q;

  lbbc_pkg::entry_t                mem_q [lbbc_pkg::ENTRIES];
  lbbc_pkg::entry_t                rd_q, mem_wd;
  logic                            mem_we;
  logic [lbbc_pkg::IDX_W-1:0]      mem_wa;

  logic [lbbc_pkg::IDX_W-1:0]      free_slot;
  logic                            sweep_end, chk_live;
  logic [60:0]                     prod;
  logic [32:0]                     cost_raw;
  logic [lbbc_pkg::TOT_W:0]        tot_sum;
  logic [lbbc_pkg::TOT_W-1:0]      tot_evict;
  logic [lbbc_pkg::CNT_W-1:0]      count_m1;

  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign sweep_end   = chk_v_q && (chk_idx_q == LAST_IDX);
  assign chk_live    = chk_v_q && valid_q[chk_idx_q];
  assign count_m1    = count_q - lbbc_pkg::CNT_W'(1);

  assign prod     = {phi_q, 16'b0} + {15'b0, plo_q};
  assign cost_raw = {prod[60:30], 2'b00} + lbbc_pkg::COST_BASE;
  assign tot_sum  = {1'b0, total_q} + {10'b0, cost_q};
  assign tot_evict = (count_m1 == '0) ? '0 :
                     (total_q > {9'b0, vic_cost_q}) ? total_q - {9'b0, vic_cost_q} : '0;

  always_comb begin
    free_slot = '0;
    for (int i = lbbc_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) free_slot = lbbc_pkg::IDX_W'(i);
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = chk_idx_q;
    mem_wd = rd_q;
    case (state_q)
      ST_TOUCH: begin
        if (chk_live) begin
          if (chk_idx_q == hit_slot_q) begin
            mem_we      = 1'b1;
            mem_wd.rank = count_m1[lbbc_pkg::IDX_W-1:0];
          end else if (rd_q.rank > hit_rank_q) begin
            mem_we      = 1'b1;
            mem_wd.rank = rd_q.rank - lbbc_pkg::IDX_W'(1);
          end
        end
      end
      ST_EVICT: begin
        if (chk_live && rd_q.rank != '0) begin
          mem_we      = 1'b1;
          mem_wd.rank = rd_q.rank - lbbc_pkg::IDX_W'(1);
        end
      end
      ST_INS_WR: begin
        mem_we = 1'b1;
        mem_wa = free_slot;
        mem_wd = '{key: key_q, cost: cost_q, rank: count_q[lbbc_pkg::IDX_W-1:0]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    rd_q <= mem_q[ctr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      count_q     <= '0;
      total_q     <= '0;
      budget_q    <= lbbc_pkg::TOT_W'(268435456);
      sweep_on_q  <= 1'b0;
      chk_v_q     <= 1'b0;
      ctr_q       <= '0;
      res_valid_o <= 1'b0;
    end else begin
      res_valid_o <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) budget_q <= cfg_data_i;

      chk_idx_q <= ctr_q;
      chk_v_q   <= sweep_on_q;
      if (sweep_on_q) begin
        ctr_q <= ctr_q + lbbc_pkg::IDX_W'(1);
        if (ctr_q == LAST_IDX) sweep_on_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            key_q     <= {file_id_i, mip_level_i};
            load_ok_q <= load_ok_i;
            w_q       <= tex_width_i;
            h_q       <= tex_height_i;
            hit_q     <= 1'b0;
            case (req_type_i)
              lbbc_pkg::REQ_ACCESS: begin
                state_q    <= ST_LOOK;
                sweep_on_q <= 1'b1;
                ctr_q      <= '0;
              end
              lbbc_pkg::REQ_SHRINK: state_q <= ST_SHR_CHK;
              lbbc_pkg::REQ_CLEAR: begin
                valid_q         <= '0;
                count_q         <= '0;
                total_q         <= '0;
                res_valid_o     <= 1'b1;
                result_kind_o   <= lbbc_pkg::KIND_CLEARED;
                slot_o          <= '0;
                out_file_id_o   <= '0;
                out_mip_level_o <= '0;
                total_bytes_o   <= '0;
                last_o          <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        ST_LOOK: begin
          if (chk_live && rd_q.key == key_q) begin
            hit_q      <= 1'b1;
            hit_slot_q <= chk_idx_q;
            hit_rank_q <= rd_q.rank;
          end
          if (sweep_end) begin
            if (hit_q || (chk_live && rd_q.key == key_q)) begin
              state_q    <= ST_TOUCH;
              sweep_on_q <= 1'b1;
              ctr_q      <= '0;
            end else if (count_q >= FULL_CNT || valid_q == '1) begin
              state_q         <= ST_IDLE;
              res_valid_o     <= 1'b1;
              result_kind_o   <= lbbc_pkg::KIND_FULL;
              slot_o          <= '0;
              out_file_id_o   <= '0;
              out_mip_level_o <= '0;
              total_bytes_o   <= total_q;
              last_o          <= 1'b1;
            end else begin
              state_q <= ST_INS_N;
            end
          end
        end
        ST_TOUCH: begin
          if (sweep_end) begin
            state_q         <= ST_IDLE;
            res_valid_o     <= 1'b1;
            result_kind_o   <= lbbc_pkg::KIND_HIT;
            slot_o          <= hit_slot_q;
            out_file_id_o   <= key_q[lbbc_pkg::KEY_W-1:lbbc_pkg::MIP_W];
            out_mip_level_o <= key_q[lbbc_pkg::MIP_W-1:0];
            total_bytes_o   <= total_q;
            last_o          <= 1'b1;
          end
        end
        ST_INS_N: begin
          n_q     <= w_q * h_q;
          state_q <= ST_INS_LO;
        end
        ST_INS_LO: begin
          plo_q   <= n_q * lbbc_pkg::COST_MUL_LO;
          state_q <= ST_INS_HI;
        end
        ST_INS_HI: begin
          phi_q   <= n_q * lbbc_pkg::COST_MUL_HI;
          state_q <= ST_INS_COST;
        end
        ST_INS_COST: begin
          if (!load_ok_q) cost_q <= '0;
          else if (cost_raw > {2'b0, lbbc_pkg::COST_MAX}) cost_q <= lbbc_pkg::COST_MAX;
          else cost_q <= cost_raw[lbbc_pkg::COST_W-1:0];
          state_q <= ST_INS_WR;
        end
        ST_INS_WR: begin
          valid_q[free_slot] <= 1'b1;
          count_q            <= count_q + lbbc_pkg::CNT_W'(1);
          total_q            <= tot_sum[lbbc_pkg::TOT_W] ? lbbc_pkg::TOT_MAX
                                                         : tot_sum[lbbc_pkg::TOT_W-1:0];
          state_q            <= ST_IDLE;
          res_valid_o        <= 1'b1;
          result_kind_o      <= lbbc_pkg::KIND_INSERT;
          slot_o             <= free_slot;
          out_file_id_o      <= key_q[lbbc_pkg::KEY_W-1:lbbc_pkg::MIP_W];
          out_mip_level_o    <= key_q[lbbc_pkg::MIP_W-1:0];
          total_bytes_o      <= tot_sum[lbbc_pkg::TOT_W] ? lbbc_pkg::TOT_MAX
                                                         : tot_sum[lbbc_pkg::TOT_W-1:0];
          last_o             <= 1'b1;
        end
        ST_SHR_CHK: begin
          if (evict_pend_q) begin
            // victim commit; the budget check runs again next cycle
            valid_q[vic_slot_q] <= 1'b0;
            count_q             <= count_m1;
            total_q             <= tot_evict;
            res_valid_o         <= 1'b1;
            result_kind_o       <= lbbc_pkg::KIND_EVICT;
            slot_o              <= vic_slot_q;
            out_file_id_o       <= vic_key_q[lbbc_pkg::KEY_W-1:lbbc_pkg::MIP_W];
            out_mip_level_o     <= vic_key_q[lbbc_pkg::MIP_W-1:0];
            total_bytes_o       <= tot_evict;
            last_o              <= 1'b0;
          end else if (total_q > budget_q && count_q != '0) begin
            state_q    <= ST_EVICT;
            sweep_on_q <= 1'b1;
            ctr_q      <= '0;
          end else begin
            if (count_q == '0) total_q <= '0;
            state_q         <= ST_IDLE;
            res_valid_o     <= 1'b1;
            result_kind_o   <= lbbc_pkg::KIND_SHRUNK;
            slot_o          <= '0;
            out_file_id_o   <= '0;
            out_mip_level_o <= '0;
            total_bytes_o   <= (count_q == '0) ? '0 : total_q;
            last_o          <= 1'b1;
          end
        end
        ST_EVICT: begin
          if (chk_live && rd_q.rank == '0) begin
            vic_slot_q <= chk_idx_q;
            vic_key_q  <= rd_q.key;
            vic_cost_q <= rd_q.cost;
          end
          // victim of the final slot is taken from the read port directly
          if (sweep_end) begin
            state_q <= ST_SHR_CHK;
            if (chk_live && rd_q.rank == '0) begin
              vic_slot_q <= chk_idx_q;
              vic_key_q  <= rd_q.key;
              vic_cost_q <= rd_q.cost;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Marks the ST_SHR_CHK cycle that commits the victim of the last sweep.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evict_pend_q <= 1'b0;
    end else begin
      evict_pend_q <= (state_q == ST_EVICT) && sweep_end;
    end
  end

  property p_count_bound;
    @(posedge clk_i) disable iff (!rst_ni) count_q <= FULL_CNT;
  endproperty
  a_count_bound: assert property (p_count_bound) else $error("entry count overflow");

  property p_count_pop;
    @(posedge clk_i) disable iff (!rst_ni)
      (state_q == ST_IDLE) |-> ($countones(valid_q) == 32'(count_q));
  endproperty
  a_count_pop: assert property (p_count_pop) else $error("count and valid bits disagree");

  property p_last_idle;
    @(posedge clk_i) disable iff (!rst_ni) (res_valid_o && last_o) |-> !busy;
  endproperty
  a_last_idle: assert property (p_last_idle) else $error("busy after final result");

  property p_access_busy;
    @(posedge clk_i) disable iff (!rst_ni)
      (start && !busy && req_type_i == lbbc_pkg::REQ_ACCESS) |=> busy;
  endproperty
  a_access_busy: assert property (p_access_busy) else $error("access not taken");

endmodule
